/* src/cau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NIB_W  = 4;

    typedef enum logic [3:0] {
        OP_ADD8    = 4'd0,
        OP_SUB8    = 4'd1,
        OP_ADD16LO = 4'd2,
        OP_ADD16HI = 4'd3,
        OP_SHL     = 4'd4,
        OP_SHR     = 4'd5,
        OP_SAR     = 4'd6,
        OP_ROL     = 4'd7,
        OP_ROR     = 4'd8,
        OP_RCL     = 4'd9,
        OP_RCR     = 4'd10
    } op_t;

    // beat leaving the decode stage: low byte arithmetic already done
    typedef struct packed {
        op_t                 op;
        logic                bad;
        logic [BYTE_W-1:0]   a_lo;
        logic [BYTE_W-1:0]   a_hi;
        logic [BYTE_W-1:0]   b_hi;
        logic                carry_in;
        logic [BYTE_W:0]     lo_sum;    // bit 8: carry out or borrow
        logic                lo_half;   // nibble carry or borrow
    } dec_t;

    // beat leaving the execute stage: value and flags except Z
    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic                n;
        logic                h;
        logic                c;
        logic                bad;
    } exe_t;

endpackage

`default_nettype wire

/* src/cau_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module cau_decode
    import cau_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [3:0]        operation,
    input  wire logic [DATA_W-1:0] operand_a,
    input  wire logic [DATA_W-1:0] operand_b,
    input  wire logic              carry_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dec_t                   out_data
);

    logic valid_reg;
    dec_t data_reg;
    dec_t data_next;

    op_t                op;
    logic               cin_eff;
    logic [BYTE_W:0]    a9;
    logic [BYTE_W:0]    b9;
    logic [NIB_W:0]     a5;
    logic [NIB_W:0]     b5;
    logic [NIB_W:0]     nib;

    always_comb begin
        op      = op_t'(operation);
        cin_eff = carry_in & ((operation == OP_ADD8) || (operation == OP_SUB8));
        a9      = {1'b0, operand_a[BYTE_W-1:0]};
        b9      = {1'b0, operand_b[BYTE_W-1:0]};
        a5      = {1'b0, operand_a[NIB_W-1:0]};
        b5      = {1'b0, operand_b[NIB_W-1:0]};

        data_next          = '0;
        data_next.op       = op;
        data_next.bad      = (operation > OP_RCR);
        data_next.a_lo     = operand_a[BYTE_W-1:0];
        data_next.a_hi     = operand_a[DATA_W-1:BYTE_W];
        data_next.b_hi     = operand_b[DATA_W-1:BYTE_W];
        data_next.carry_in = carry_in;

        // 9-bit difference goes negative exactly when b + borrow exceeds a
        if (operation == OP_SUB8) begin
            data_next.lo_sum = a9 - b9 - {{BYTE_W{1'b0}}, cin_eff};
            nib              = a5 - b5 - {{NIB_W{1'b0}}, cin_eff};
        end else begin
            data_next.lo_sum = a9 + b9 + {{BYTE_W{1'b0}}, cin_eff};
            nib              = a5 + b5 + {{NIB_W{1'b0}}, cin_eff};
        end
        data_next.lo_half = nib[NIB_W];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* src/cau_execute.sv */
`timescale 1ns / 1ps
`default_nettype none

module cau_execute
    import cau_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  dec_t      in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output exe_t      out_data
);

    logic valid_reg;
    exe_t data_reg;
    exe_t data_next;

    logic [BYTE_W:0]   hi_sum;
    logic [NIB_W:0]    hi_nib;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] v8;
    logic              c8;

    always_comb begin
        a      = in_data.a_lo;
        // high byte of the 16-bit add, rippled from the low byte carry
        hi_sum = {1'b0, in_data.a_hi} + {1'b0, in_data.b_hi}
               + {{BYTE_W{1'b0}}, in_data.lo_sum[BYTE_W]};
        hi_nib = {1'b0, in_data.a_hi[NIB_W-1:0]} + {1'b0, in_data.b_hi[NIB_W-1:0]}
               + {{NIB_W{1'b0}}, in_data.lo_sum[BYTE_W]};

        data_next = '0;
        v8        = '0;
        c8        = 1'b0;

        if (!in_data.bad) begin
            unique case (in_data.op)
                OP_ADD8: begin
                    v8          = in_data.lo_sum[BYTE_W-1:0];
                    c8          = in_data.lo_sum[BYTE_W];
                    data_next.h = in_data.lo_half;
                end
                OP_SUB8: begin
                    v8          = in_data.lo_sum[BYTE_W-1:0];
                    c8          = in_data.lo_sum[BYTE_W];
                    data_next.h = in_data.lo_half;
                    data_next.n = 1'b1;
                end
                OP_SHL: begin
                    v8 = {a[BYTE_W-2:0], 1'b0};
                    c8 = a[BYTE_W-1];
                end
                OP_SHR: begin
                    v8 = {1'b0, a[BYTE_W-1:1]};
                    c8 = a[0];
                end
                OP_SAR: begin
                    v8 = {a[BYTE_W-1], a[BYTE_W-1:1]};
                    c8 = a[0];
                end
                OP_ROL: begin
                    v8 = {a[BYTE_W-2:0], a[BYTE_W-1]};
                    c8 = a[BYTE_W-1];
                end
                OP_ROR: begin
                    v8 = {a[0], a[BYTE_W-1:1]};
                    c8 = a[0];
                end
                OP_RCL: begin
                    v8 = {a[BYTE_W-2:0], in_data.carry_in};
                    c8 = a[BYTE_W-1];
                end
                OP_RCR: begin
                    v8 = {in_data.carry_in, a[BYTE_W-1:1]};
                    c8 = a[0];
                end
                default: begin
                    v8 = '0;
                    c8 = 1'b0;
                end
            endcase

            if (in_data.op == OP_ADD16LO || in_data.op == OP_ADD16HI) begin
                data_next.value = {hi_sum[BYTE_W-1:0], in_data.lo_sum[BYTE_W-1:0]};
                if (in_data.op == OP_ADD16LO) begin
                    data_next.h = in_data.lo_half;
                    data_next.c = in_data.lo_sum[BYTE_W];
                end else begin
                    data_next.h = hi_nib[NIB_W];
                    data_next.c = hi_sum[BYTE_W];
                end
            end else begin
                data_next.value = {{BYTE_W{1'b0}}, v8};
                data_next.c     = c8;
            end
        end
        data_next.bad = in_data.bad;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* src/cau_flags.sv */
`timescale 1ns / 1ps
`default_nettype none

module cau_flags
    import cau_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  exe_t              in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output exe_t              out_data,
    output logic              out_zero
);

    logic valid_reg;
    exe_t data_reg;
    logic zero_reg;
    logic zero_next;

    // undefined codes report Z clear even though the value is zero
    assign zero_next = (in_data.value == '0) && !in_data.bad;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_zero  = zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= in_data;
            zero_reg <= zero_next;
        end
    end

endmodule

`default_nettype wire

/* src/cpu_alu_with_flags_unit.sv */
// Path: an accepted input beat passes the decode, execute and flags stage registers to the outputs.
// Throughput: one beat per cycle while m_ready stays high; the three-stage register pipeline is the limit.
// A stalled stage holds its beat; empty stages ahead of it still take new beats.
// Reset: synchronous, active low aresetn; clears all stage valid bits, data is not reset.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_with_flags_unit
    import cau_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [3:0]        s_operation,
    input  wire logic [DATA_W-1:0] s_operand_a,
    input  wire logic [DATA_W-1:0] s_operand_b,
    input  wire logic              s_carry_in,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_result_value,
    output logic                   m_flag_zero,
    output logic                   m_flag_subtract,
    output logic                   m_flag_half_carry,
    output logic                   m_flag_carry,
    output logic                   m_bad_operation
);

    logic dec_valid;
    logic dec_ready;
    dec_t dec_data;
    logic exe_valid;
    logic exe_ready;
    exe_t exe_data;
    exe_t res_data;

    cau_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .operation (s_operation),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .carry_in  (s_carry_in),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    cau_execute u_execute (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (exe_valid),
        .out_ready (exe_ready),
        .out_data  (exe_data)
    );

    cau_flags u_flags (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (exe_valid),
        .in_ready  (exe_ready),
        .in_data   (exe_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_data),
        .out_zero  (m_flag_zero)
    );

    assign m_result_value    = res_data.value;
    assign m_flag_subtract   = res_data.n;
    assign m_flag_half_carry = res_data.h;
    assign m_flag_carry      = res_data.c;
    assign m_bad_operation   = res_data.bad;

endmodule

`default_nettype wire

/* src/cau_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cau_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [15:0] m_result_value,
    input wire logic        m_flag_zero,
    input wire logic        m_flag_subtract,
    input wire logic        m_flag_half_carry,
    input wire logic        m_flag_carry,
    input wire logic        m_bad_operation
);

    // a stalled result beat must not vanish
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_operation |-> m_result_value == 16'd0 && !m_flag_zero
            && !m_flag_subtract && !m_flag_half_carry && !m_flag_carry)
        else $error("undefined operation with non-zero outputs");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_bad_operation |-> m_flag_zero == (m_result_value == 16'd0))
        else $error("zero flag disagrees with result");

    a_sub_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flag_subtract |-> m_result_value[15:8] == 8'd0 && !m_bad_operation)
        else $error("subtract result with upper byte set");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind cpu_alu_with_flags_unit cau_checker u_cau_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_result_value    (m_result_value),
    .m_flag_zero       (m_flag_zero),
    .m_flag_subtract   (m_flag_subtract),
    .m_flag_half_carry (m_flag_half_carry),
    .m_flag_carry      (m_flag_carry),
    .m_bad_operation   (m_bad_operation)
);

`default_nettype wire
